>>> rtl/fsms_pkg.sv
// Package with the types, constants and distance functions of the font style match selector.
`timescale 1ns / 1ps

package fsms_pkg;

   localparam int ID_BITS        = 8;
   localparam int VALUE_BITS     = 16;
   localparam int CALC_BITS      = VALUE_BITS + 2;
   localparam int WEIGHT_BITS    = 12;
   localparam int WIDTH_BITS     = 10;
   localparam int SLOPE_BITS     = 10;
   localparam int ITALIC_BITS    = 9;
   localparam int WD_DIST_BITS   = 11;
   localparam int SL_DIST_BITS   = 11;
   localparam int WT_DIST_BITS   = 13;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic signed [CALC_BITS-1:0]  calc_type;

   localparam value_type VALUE_TOP    = value_type'({1'b0, {(VALUE_BITS-1){1'b1}}});
   localparam value_type VALUE_BOTTOM = value_type'({1'b1, {(VALUE_BITS-1){1'b0}}});

   localparam calc_type WEIGHT_LOWER_Q2 = calc_type'(1600);
   localparam calc_type WEIGHT_UPPER_Q2 = calc_type'(2000);

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_EVAL  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REQUEST_WEIGHT = 3'd0,
      CSR_REQUEST_WIDTH  = 3'd1,
      CSR_REQUEST_SLOPE  = 3'd2,
      CSR_NORMAL_WIDTH   = 3'd3,
      CSR_ITALIC_SLOPE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        [WEIGHT_BITS-1:0] weight_lo;
      logic        [WEIGHT_BITS-1:0] weight_hi;
      logic        [WIDTH_BITS-1:0]  width_lo;
      logic        [WIDTH_BITS-1:0]  width_hi;
      logic signed [SLOPE_BITS-1:0]  slope_lo;
      logic signed [SLOPE_BITS-1:0]  slope_hi;
   } ranges_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [ID_BITS-1:0] candidate_id;
      ranges_type         ranges;
   } item_type;

   typedef struct packed {
      value_type weight_min;
      value_type weight_max;
      value_type width_min;
      value_type width_max;
      value_type slope_min;
      value_type slope_max;
   } bounds_type;

   localparam bounds_type BOUNDS_RESET = '{
      weight_min: VALUE_TOP, weight_max: VALUE_BOTTOM,
      width_min:  VALUE_TOP, width_max:  VALUE_BOTTOM,
      slope_min:  VALUE_TOP, slope_max:  VALUE_BOTTOM
   };

   typedef struct packed {
      logic        [WEIGHT_BITS-1:0] request_weight;
      logic        [WIDTH_BITS-1:0]  request_width;
      logic signed [SLOPE_BITS-1:0]  request_slope;
      logic        [WIDTH_BITS-1:0]  normal_width;
      logic        [ITALIC_BITS-1:0] italic_slope;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      request_weight: 12'd1600,
      request_width:  10'd400,
      request_slope:  10'sd0,
      normal_width:   10'd400,
      italic_slope:   9'd80
   };

   typedef struct packed {
      logic                    is_better;
      logic [ID_BITS-1:0]      best_id;
      logic [WD_DIST_BITS-1:0] width_dist;
      logic [SL_DIST_BITS-1:0] slope_dist;
      logic [WT_DIST_BITS-1:0] weight_dist;
   } result_type;

   function automatic calc_type min_calc(calc_type a, calc_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic calc_type max_calc(calc_type a, calc_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic calc_type dist_width(calc_type lo, calc_type hi, calc_type q,
                                           calc_type nrm, calc_type bmax, calc_type bmin);
      calc_type d;
      if (q >= lo && q <= hi) begin
         d = '0;
      end else if (q > nrm) begin
         if (lo > q) d = lo - q;
         else d = max_calc(q, bmax) - hi;
      end else begin
         if (hi < q) d = q - hi;
         else d = lo - min_calc(q, bmin);
      end
      return d;
   endfunction

   function automatic calc_type dist_slope(calc_type lo, calc_type hi, calc_type q,
                                           calc_type it, calc_type bmax, calc_type bmin);
      calc_type d;
      if (q >= lo && q <= hi) begin
         d = '0;
      end else if (q >= it) begin
         if (lo > q) d = lo - q;
         else d = max_calc(q, bmax) - hi;
      end else if (q >= 0) begin
         if (hi >= 0 && hi < q) d = q - hi;
         else if (lo > q) d = lo;
         else d = max_calc(q, bmax) - hi;
      end else if (q > -it) begin
         if (lo > q && lo <= 0) d = lo - q;
         else if (hi < q) d = -hi;
         else d = lo - min_calc(q, bmin);
      end else begin
         if (hi < q) d = q - hi;
         else d = lo - min_calc(q, bmin);
      end
      return d;
   endfunction

   function automatic calc_type dist_weight(calc_type lo, calc_type hi, calc_type q,
                                            calc_type bmax, calc_type bmin);
      calc_type d;
      if (q >= lo && q <= hi) begin
         d = '0;
      end else if (q >= WEIGHT_LOWER_Q2 && q <= WEIGHT_UPPER_Q2) begin
         if (lo > q && lo <= WEIGHT_UPPER_Q2) d = lo - q;
         else if (hi < q) d = WEIGHT_UPPER_Q2 - hi;
         else d = lo - min_calc(q, bmin);
      end else if (q < WEIGHT_LOWER_Q2) begin
         if (hi < q) d = q - hi;
         else d = lo - min_calc(q, bmin);
      end else begin
         if (lo > q) d = lo - q;
         else d = max_calc(q, bmax) - hi;
      end
      return d;
   endfunction

endpackage

>>> rtl/fsms_if.sv
// Channel interfaces for the request, response and register write ports.
`timescale 1ns / 1ps

interface fsms_req_if;
   import fsms_pkg::*;
   logic                           valid;
   logic                           ready;
   logic        [1:0]              cmd;
   logic        [ID_BITS-1:0]      candidate_id;
   logic        [WEIGHT_BITS-1:0]  weight_lo;
   logic        [WEIGHT_BITS-1:0]  weight_hi;
   logic        [WIDTH_BITS-1:0]   width_lo;
   logic        [WIDTH_BITS-1:0]   width_hi;
   logic signed [SLOPE_BITS-1:0]   slope_lo;
   logic signed [SLOPE_BITS-1:0]   slope_hi;

   modport source (output valid, cmd, candidate_id, weight_lo, weight_hi, width_lo, width_hi,
                   slope_lo, slope_hi, input ready);
   modport sink (input valid, cmd, candidate_id, weight_lo, weight_hi, width_lo, width_hi,
                 slope_lo, slope_hi, output ready);
endinterface

interface fsms_rsp_if;
   import fsms_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    is_better;
   logic [ID_BITS-1:0]      best_id;
   logic [WD_DIST_BITS-1:0] width_dist;
   logic [SL_DIST_BITS-1:0] slope_dist;
   logic [WT_DIST_BITS-1:0] weight_dist;

   modport source (output valid, is_better, best_id, width_dist, slope_dist, weight_dist,
                   input ready);
   modport sink (input valid, is_better, best_id, width_dist, slope_dist, weight_dist,
                 output ready);
endinterface

interface fsms_csr_if;
   import fsms_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/fsms_csr.sv
// Configuration registers holding the requested style and the width and italic thresholds.
`timescale 1ns / 1ps

module fsms_csr (
   input  logic             clock,
   input  logic             reset,
   fsms_csr_if.sink         csr_bus,
   output fsms_pkg::cfg_type cfg
);
   import fsms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign csr_bus.ready = 1'b1;
   assign write_en      = csr_bus.valid && csr_bus.ready;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_REQUEST_WEIGHT: cfg_in.request_weight = WEIGHT_BITS'(csr_bus.data);
            CSR_REQUEST_WIDTH:  cfg_in.request_width  = WIDTH_BITS'(csr_bus.data);
            CSR_REQUEST_SLOPE:  cfg_in.request_slope  = SLOPE_BITS'(csr_bus.data);
            CSR_NORMAL_WIDTH:   cfg_in.normal_width   = WIDTH_BITS'(csr_bus.data);
            CSR_ITALIC_SLOPE:   cfg_in.italic_slope   = ITALIC_BITS'(csr_bus.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/fsms_eval.sv
// Distance computation and best-candidate comparison for one registered word.
`timescale 1ns / 1ps

module fsms_eval (
   input  fsms_pkg::item_type             item,
   input  fsms_pkg::cfg_type              cfg,
   input  fsms_pkg::bounds_type           bounds,
   input  fsms_pkg::ranges_type           best,
   input  logic                           have_best,
   input  logic [fsms_pkg::ID_BITS-1:0]   best_ident,
   output fsms_pkg::result_type           result,
   output logic                           take
);
   import fsms_pkg::*;

   calc_type q_weight;
   calc_type q_width;
   calc_type q_slope;
   calc_type q_normal;
   calc_type q_italic;
   calc_type cand_wd;
   calc_type cand_sl;
   calc_type cand_wt;
   calc_type best_wd;
   calc_type best_sl;
   calc_type best_wt;

   assign q_weight = CALC_BITS'(cfg.request_weight);
   assign q_width  = CALC_BITS'(cfg.request_width);
   assign q_slope  = CALC_BITS'(cfg.request_slope);
   assign q_normal = CALC_BITS'(cfg.normal_width);
   assign q_italic = CALC_BITS'(cfg.italic_slope);

   // The stored best is scored again against the current bounds.
   assign cand_wd = dist_width(CALC_BITS'(item.ranges.width_lo), CALC_BITS'(item.ranges.width_hi),
                               q_width, q_normal, CALC_BITS'(bounds.width_max),
                               CALC_BITS'(bounds.width_min));
   assign cand_sl = dist_slope(CALC_BITS'(item.ranges.slope_lo), CALC_BITS'(item.ranges.slope_hi),
                               q_slope, q_italic, CALC_BITS'(bounds.slope_max),
                               CALC_BITS'(bounds.slope_min));
   assign cand_wt = dist_weight(CALC_BITS'(item.ranges.weight_lo),
                                CALC_BITS'(item.ranges.weight_hi), q_weight,
                                CALC_BITS'(bounds.weight_max), CALC_BITS'(bounds.weight_min));
   assign best_wd = dist_width(CALC_BITS'(best.width_lo), CALC_BITS'(best.width_hi),
                               q_width, q_normal, CALC_BITS'(bounds.width_max),
                               CALC_BITS'(bounds.width_min));
   assign best_sl = dist_slope(CALC_BITS'(best.slope_lo), CALC_BITS'(best.slope_hi),
                               q_slope, q_italic, CALC_BITS'(bounds.slope_max),
                               CALC_BITS'(bounds.slope_min));
   assign best_wt = dist_weight(CALC_BITS'(best.weight_lo), CALC_BITS'(best.weight_hi),
                                q_weight, CALC_BITS'(bounds.weight_max),
                                CALC_BITS'(bounds.weight_min));

   always_comb begin
      take   = 1'b0;
      result = '0;
      unique case (cmd_type'(item.cmd))
         CMD_CLEAR: begin
            result.best_id = '0;
         end
         CMD_ADD: begin
            result.best_id = best_ident;
         end
         CMD_EVAL: begin
            if (!have_best) take = 1'b1;
            else if (cand_wd != best_wd) take = cand_wd < best_wd;
            else if (cand_sl != best_sl) take = cand_sl < best_sl;
            else take = cand_wt < best_wt;
            result.is_better   = take;
            result.best_id     = take ? item.candidate_id : best_ident;
            result.width_dist  = WD_DIST_BITS'(cand_wd);
            result.slope_dist  = SL_DIST_BITS'(cand_sl);
            result.weight_dist = WT_DIST_BITS'(cand_wt);
         end
         default: begin
            result.best_id = best_ident;
         end
      endcase
   end

endmodule

>>> rtl/fsms_core.sv
// Input register, running bounds, stored best and response register around the evaluator.
`timescale 1ns / 1ps

module fsms_core (
   input  logic              clock,
   input  logic              reset,
   input  fsms_pkg::cfg_type cfg,
   fsms_req_if.sink          req_bus,
   fsms_rsp_if.source        rsp_bus
);
   import fsms_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   item_type           item_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   result_type         rsp_ff;
   bounds_type         bounds_ff;
   bounds_type         bounds_in;
   ranges_type         best_ff;
   logic [ID_BITS-1:0] best_ident_ff;
   logic [ID_BITS-1:0] best_ident_in;
   logic               have_best_ff;
   logic               have_best_in;
   logic               req_accept;
   logic               advance;
   result_type         result;
   logic               take;

   // A word moves to the response register whenever that register is empty or drained.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   fsms_eval u_eval (
      .item       (item_ff),
      .cfg        (cfg),
      .bounds     (bounds_ff),
      .best       (best_ff),
      .have_best  (have_best_ff),
      .best_ident (best_ident_ff),
      .result     (result),
      .take       (take)
   );

   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_comb begin
      bounds_in     = bounds_ff;
      best_ident_in = best_ident_ff;
      have_best_in  = have_best_ff;
      if (advance) begin
         unique case (cmd_type'(item_ff.cmd))
            CMD_CLEAR: begin
               bounds_in     = BOUNDS_RESET;
               best_ident_in = '0;
               have_best_in  = 1'b0;
            end
            CMD_ADD: begin
               bounds_in.weight_min = VALUE_BITS'(min_calc(CALC_BITS'(bounds_ff.weight_min),
                                                  CALC_BITS'(item_ff.ranges.weight_lo)));
               bounds_in.weight_max = VALUE_BITS'(max_calc(CALC_BITS'(bounds_ff.weight_max),
                                                  CALC_BITS'(item_ff.ranges.weight_hi)));
               bounds_in.width_min  = VALUE_BITS'(min_calc(CALC_BITS'(bounds_ff.width_min),
                                                  CALC_BITS'(item_ff.ranges.width_lo)));
               bounds_in.width_max  = VALUE_BITS'(max_calc(CALC_BITS'(bounds_ff.width_max),
                                                  CALC_BITS'(item_ff.ranges.width_hi)));
               bounds_in.slope_min  = VALUE_BITS'(min_calc(CALC_BITS'(bounds_ff.slope_min),
                                                  CALC_BITS'(item_ff.ranges.slope_lo)));
               bounds_in.slope_max  = VALUE_BITS'(max_calc(CALC_BITS'(bounds_ff.slope_max),
                                                  CALC_BITS'(item_ff.ranges.slope_hi)));
            end
            CMD_EVAL: begin
               if (take) begin
                  best_ident_in = item_ff.candidate_id;
                  have_best_in  = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         bounds_ff     <= BOUNDS_RESET;
         best_ident_ff <= '0;
         have_best_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         bounds_ff     <= bounds_in;
         best_ident_ff <= best_ident_in;
         have_best_ff  <= have_best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.cmd              <= req_bus.cmd;
         item_ff.candidate_id     <= req_bus.candidate_id;
         item_ff.ranges.weight_lo <= req_bus.weight_lo;
         item_ff.ranges.weight_hi <= req_bus.weight_hi;
         item_ff.ranges.width_lo  <= req_bus.width_lo;
         item_ff.ranges.width_hi  <= req_bus.width_hi;
         item_ff.ranges.slope_lo  <= req_bus.slope_lo;
         item_ff.ranges.slope_hi  <= req_bus.slope_hi;
      end
      if (advance) begin
         rsp_ff <= result;
      end
      if (advance && take) begin
         best_ff <= item_ff.ranges;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.is_better   = rsp_ff.is_better;
   assign rsp_bus.best_id     = rsp_ff.best_id;
   assign rsp_bus.width_dist  = rsp_ff.width_dist;
   assign rsp_bus.slope_dist  = rsp_ff.slope_dist;
   assign rsp_bus.weight_dist = rsp_ff.weight_dist;

   // Without a stored best the identifier reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      !have_best_ff |-> best_ident_ff == '0)
      else $error("best identifier set without a stored best");

   assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.cmd == CMD_CLEAR |=> !have_best_ff && out_valid_ff)
      else $error("clear word left a stored best");

   assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.cmd == CMD_EVAL && !have_best_ff |-> take && result.is_better)
      else $error("first evaluated candidate was not taken");

   assert property (@(posedge clock) disable iff (reset)
      advance && take |=> have_best_ff && rsp_bus.best_id == best_ident_ff)
      else $error("new best not reflected in the response");

   assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.cmd != CMD_EVAL |-> !take && !result.is_better)
      else $error("candidate taken on a word that does not evaluate");

endmodule

>>> rtl/font_style_match_selector_top.sv
// Top level of the font style match selector: register block and matching core.
// Each accepted word waits in the input register, then its response in the response register;
// the two decouple the channels. Throughput: one word per cycle unless the response
// channel stalls; bounds and stored best update as each word leaves the input register.
// Reset (synchronous, active high) empties both registers, clears bounds and stored best.
`timescale 1ns / 1ps

module font_style_match_selector_top (
   input  logic       clock,
   input  logic       reset,
   fsms_req_if.sink   req_bus,
   fsms_rsp_if.source rsp_bus,
   fsms_csr_if.sink   csr_bus
);
   import fsms_pkg::*;

   cfg_type cfg;

   fsms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   fsms_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> test/font_style_match_selector_top_test.sv
// Randomized self-checking testbench of the font style match selector with a predicting scoreboard.
`timescale 1ns / 1ps

module font_style_match_selector_top_test;
   import fsms_pkg::*;

   localparam int PHASE_ITEMS  = 150;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int BAND_LOW     = 1600;
   localparam int BAND_HIGH    = 2000;

   class style_match_tracker;
      cfg_type    settings;
      int         weight_min, weight_max, width_min, width_max, slope_min, slope_max;
      ranges_type best_ranges;
      logic [ID_BITS-1:0] best_ident;
      bit         have_best;
      result_type awaited_results[$];
      int         faults;

      function new();
         settings = CFG_RESET;
         clear_bounds();
         best_ranges = '0;
         best_ident = '0;
         have_best = 1'b0;
         faults = 0;
      endfunction

      function void clear_bounds();
         weight_min = int'(VALUE_TOP);
         width_min = int'(VALUE_TOP);
         slope_min = int'(VALUE_TOP);
         weight_max = int'(VALUE_BOTTOM);
         width_max = int'(VALUE_BOTTOM);
         slope_max = int'(VALUE_BOTTOM);
      endfunction

      function int min2(int a, int b);
         return (a < b) ? a : b;
      endfunction

      function int max2(int a, int b);
         return (a > b) ? a : b;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_REQUEST_WEIGHT: settings.request_weight = data[WEIGHT_BITS-1:0];
            CSR_REQUEST_WIDTH:  settings.request_width = data[WIDTH_BITS-1:0];
            CSR_REQUEST_SLOPE:  settings.request_slope = data[SLOPE_BITS-1:0];
            CSR_NORMAL_WIDTH:   settings.normal_width = data[WIDTH_BITS-1:0];
            CSR_ITALIC_SLOPE:   settings.italic_slope = data[ITALIC_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int width_gap(ranges_type r);
         int lo, hi, q;
         lo = r.width_lo;
         hi = r.width_hi;
         q = settings.request_width;
         if (q >= lo && q <= hi) return 0;
         if (q > int'(settings.normal_width)) return (lo > q) ? lo - q : max2(q, width_max) - hi;
         return (hi < q) ? q - hi : lo - min2(q, width_min);
      endfunction

      function int slope_gap(ranges_type r);
         int lo, hi, q, it;
         lo = $signed(r.slope_lo);
         hi = $signed(r.slope_hi);
         q = $signed(settings.request_slope);
         it = settings.italic_slope;
         if (q >= lo && q <= hi) return 0;
         if (q >= it) return (lo > q) ? lo - q : max2(q, slope_max) - hi;
         if (q >= 0) begin
            if (hi >= 0 && hi < q) return q - hi;
            if (lo > q) return lo;
            return max2(q, slope_max) - hi;
         end
         if (q > -it) begin
            if (lo > q && lo <= 0) return lo - q;
            if (hi < q) return -hi;
            return lo - min2(q, slope_min);
         end
         return (hi < q) ? q - hi : lo - min2(q, slope_min);
      endfunction

      function int weight_gap(ranges_type r);
         int lo, hi, q;
         lo = r.weight_lo;
         hi = r.weight_hi;
         q = settings.request_weight;
         if (q >= lo && q <= hi) return 0;
         if (q >= BAND_LOW && q <= BAND_HIGH) begin
            if (lo > q && lo <= BAND_HIGH) return lo - q;
            if (hi < q) return BAND_HIGH - hi;
            return lo - min2(q, weight_min);
         end
         if (q < BAND_LOW) return (hi < q) ? q - hi : lo - min2(q, weight_min);
         return (lo > q) ? lo - q : max2(q, weight_max) - hi;
      endfunction

      function void note_word(item_type w);
         result_type r;
         int cw, cs, cg, pw, ps, pg;
         bit take;
         r = '0;
         case (w.cmd)
            CMD_CLEAR: begin
               clear_bounds();
               best_ident = '0;
               have_best = 1'b0;
            end
            CMD_ADD: begin
               weight_min = min2(weight_min, w.ranges.weight_lo);
               weight_max = max2(weight_max, w.ranges.weight_hi);
               width_min = min2(width_min, w.ranges.width_lo);
               width_max = max2(width_max, w.ranges.width_hi);
               slope_min = min2(slope_min, $signed(w.ranges.slope_lo));
               slope_max = max2(slope_max, $signed(w.ranges.slope_hi));
            end
            CMD_EVAL: begin
               cw = width_gap(w.ranges);
               cs = slope_gap(w.ranges);
               cg = weight_gap(w.ranges);
               take = !have_best;
               if (have_best) begin
                  pw = width_gap(best_ranges);
                  ps = slope_gap(best_ranges);
                  pg = weight_gap(best_ranges);
                  if (cw != pw) take = cw < pw;
                  else if (cs != ps) take = cs < ps;
                  else take = cg < pg;
               end
               if (take) begin
                  best_ranges = w.ranges;
                  best_ident = w.candidate_id;
                  have_best = 1'b1;
               end
               r.is_better = take;
               r.width_dist = WD_DIST_BITS'(cw);
               r.slope_dist = SL_DIST_BITS'(cs);
               r.weight_dist = WT_DIST_BITS'(cg);
            end
            default: ;
         endcase
         r.best_id = best_ident;
         awaited_results = {awaited_results, r};
      endfunction

      function void compare_field(string what, logic [15:0] want, logic [15:0] seen);
         if (want !== seen) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, seen);
            faults++;
         end
      endfunction

      function void check_word(result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: response word with none pending, got %p", $time, got);
            faults++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("is_better", want.is_better, got.is_better);
         compare_field("best_id", want.best_id, got.best_id);
         compare_field("width_dist", want.width_dist, got.width_dist);
         compare_field("slope_dist", want.slope_dist, got.slope_dist);
         compare_field("weight_dist", want.weight_dist, got.weight_dist);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   fsms_req_if req_bus();
   fsms_rsp_if rsp_bus();
   fsms_csr_if csr_bus();

   font_style_match_selector_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   style_match_tracker tracker;
   int burst_left;
   int rcv_mode;
   int rcv_left;
   int rcv_tick;
   int cycle_count;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.is_better = rsp_bus.is_better;
         got.best_id = rsp_bus.best_id;
         got.width_dist = rsp_bus.width_dist;
         got.slope_dist = rsp_bus.slope_dist;
         got.weight_dist = rsp_bus.weight_dist;
         tracker.check_word(got);
      end
   end

   // The receiver switches between always ready, random stalls, a fixed duty cycle and long stalls.
   always @(negedge clock) begin
      if (rcv_left == 0) begin
         rcv_mode = $urandom_range(0, 3);
         rcv_left = $urandom_range(20, 80);
      end
      rcv_left--;
      rcv_tick++;
      case (rcv_mode)
         0: rsp_bus.ready = 1'b1;
         1: rsp_bus.ready = ($urandom_range(0, 3) != 0);
         2: rsp_bus.ready = ((rcv_tick % 5) < 3);
         default: rsp_bus.ready = ((rcv_tick % 12) == 0);
      endcase
   end

   function automatic ranges_type span(int wl, int wh, int dl, int dh, int sl, int sh);
      ranges_type r;
      r.weight_lo = WEIGHT_BITS'(wl);
      r.weight_hi = WEIGHT_BITS'(wh);
      r.width_lo = WIDTH_BITS'(dl);
      r.width_hi = WIDTH_BITS'(dh);
      r.slope_lo = SLOPE_BITS'(sl);
      r.slope_hi = SLOPE_BITS'(sh);
      return r;
   endfunction

   function automatic item_type make_word(cmd_type c, int id, ranges_type r);
      item_type w;
      w.cmd = c;
      w.candidate_id = ID_BITS'(id);
      w.ranges = r;
      return w;
   endfunction

   function automatic int pick_weight();
      case ($urandom_range(0, 4))
         0: return 4;
         1: return 4000;
         2: return $urandom_range(1500, 2100);
         default: return $urandom_range(4, 4000);
      endcase
   endfunction

   function automatic int pick_width();
      case ($urandom_range(0, 4))
         0: return 200;
         1: return 800;
         2: return $urandom_range(350, 450);
         default: return $urandom_range(200, 800);
      endcase
   endfunction

   function automatic int pick_slope();
      case ($urandom_range(0, 4))
         0: return -360;
         1: return 360;
         2: return int'($urandom_range(0, 200)) - 100;
         default: return int'($urandom_range(0, 720)) - 360;
      endcase
   endfunction

   // Mostly ordered pairs; about one in ten inverted pairs is left as drawn.
   function automatic void order_pair(inout int a, inout int b);
      int t;
      if (a > b && $urandom_range(0, 9) != 0) begin
         t = a;
         a = b;
         b = t;
      end
   endfunction

   function automatic ranges_type random_ranges();
      int wl, wh, dl, dh, sl, sh;
      wl = pick_weight();
      wh = pick_weight();
      dl = pick_width();
      dh = pick_width();
      sl = pick_slope();
      sh = pick_slope();
      order_pair(wl, wh);
      order_pair(dl, dh);
      order_pair(sl, sh);
      return span(wl, wh, dl, dh, sl, sh);
   endfunction

   task automatic put_word(item_type w);
      req_bus.valid = 1'b1;
      req_bus.cmd = w.cmd;
      req_bus.candidate_id = w.candidate_id;
      req_bus.weight_lo = w.ranges.weight_lo;
      req_bus.weight_hi = w.ranges.weight_hi;
      req_bus.width_lo = w.ranges.width_lo;
      req_bus.width_hi = w.ranges.width_hi;
      req_bus.slope_lo = w.ranges.slope_lo;
      req_bus.slope_hi = w.ranges.slope_hi;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      tracker.note_word(w);
      @(negedge clock);
   endtask

   task automatic send(item_type w);
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      put_word(w);
   endtask

   task automatic pause_until_drained();
      req_bus.valid = 1'b0;
      while (tracker.awaited_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int data);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = CSR_DATA_BITS'(data);
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      tracker.write_reg(idx, CSR_DATA_BITS'(data));
      @(negedge clock);
   endtask

   task automatic set_request(int weight, int width, int slope, int normal, int italic);
      write_reg(CSR_REQUEST_WEIGHT, weight);
      write_reg(CSR_REQUEST_WIDTH, width);
      write_reg(CSR_REQUEST_SLOPE, slope);
      write_reg(CSR_NORMAL_WIDTH, normal);
      write_reg(CSR_ITALIC_SLOPE, italic);
      csr_bus.valid = 1'b0;
   endtask

   task automatic random_request();
      int weight, width, slope, normal, italic;
      weight = ($urandom_range(0, 2) == 0) ? $urandom_range(BAND_LOW, BAND_HIGH)
                                           : $urandom_range(4, 4000);
      width = $urandom_range(200, 800);
      normal = ($urandom_range(0, 3) == 0) ? width : $urandom_range(200, 800);
      italic = $urandom_range(0, 360);
      case ($urandom_range(0, 2))
         0: slope = italic;
         1: slope = -italic;
         default: slope = int'($urandom_range(0, 720)) - 360;
      endcase
      set_request(weight, width, slope, normal, italic);
   endtask

   // Mostly well-formed sets: usually a clear, adds of most candidates, then evaluation of all.
   task automatic run_random(int count);
      ranges_type pool[8];
      int n, made;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 99) == 0) pause_until_drained();
         if ($urandom_range(0, 9) < 8) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) pool[k] = random_ranges();
            if ($urandom_range(0, 7) != 0) begin
               send(make_word(CMD_CLEAR, $urandom_range(0, 255), random_ranges()));
               made++;
            end
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(0, 5) != 0) begin
                  send(make_word(CMD_ADD, $urandom_range(0, 255), pool[k]));
                  made++;
               end
            end
            for (int k = 0; k < n; k++) begin
               send(make_word(CMD_EVAL, $urandom_range(0, 255), pool[k]));
               made++;
            end
            if ($urandom_range(0, 2) == 0) begin
               send(make_word(CMD_EVAL, $urandom_range(0, 255), pool[$urandom_range(0, n - 1)]));
               made++;
            end
         end else begin
            send(make_word(cmd_type'($urandom_range(0, 2)), $urandom_range(0, 255),
                           random_ranges()));
            made++;
         end
      end
   endtask

   initial begin
      tracker = new();
      burst_left = 0;
      rcv_mode = 0;
      rcv_left = 0;
      rcv_tick = 0;
      cycle_count = 0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_CLEAR;
      req_bus.candidate_id = '0;
      req_bus.weight_lo = '0;
      req_bus.weight_hi = '0;
      req_bus.width_lo = '0;
      req_bus.width_hi = '0;
      req_bus.slope_lo = '0;
      req_bus.slope_hi = '0;
      rsp_bus.ready = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_REQUEST_WEIGHT;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Evaluation before any add, ties, extremes, inverted ranges and the weight band.
      send(make_word(CMD_EVAL, 9, span(4, 4000, 200, 800, -360, 360)));
      send(make_word(CMD_CLEAR, 0, span(4, 4000, 200, 800, -360, 360)));
      send(make_word(CMD_EVAL, 1, span(4, 4000, 200, 800, -360, 360)));
      send(make_word(CMD_EVAL, 2, span(4, 4000, 200, 800, -360, 360)));
      send(make_word(CMD_EVAL, 3, span(4000, 4000, 400, 400, 0, 0)));
      send(make_word(CMD_ADD, 4, span(4, 4, 200, 200, -360, -360)));
      send(make_word(CMD_ADD, 5, span(4000, 4000, 800, 800, 360, 360)));
      send(make_word(CMD_EVAL, 255, span(4, 4, 800, 800, 360, 360)));
      send(make_word(CMD_EVAL, 0, span(4000, 4, 800, 200, 360, -360)));
      send(make_word(CMD_EVAL, 6, span(1700, 1800, 200, 300, -50, -10)));
      send(make_word(CMD_EVAL, 7, span(2100, 3000, 500, 800, 10, 50)));
      send(make_word(CMD_EVAL, 8, span(2100, 3000, 500, 800, 10, 50)));
      send(make_word(CMD_CLEAR, 255, span(4, 4, 200, 200, -360, -360)));
      send(make_word(CMD_EVAL, 170, span(4, 1000, 200, 300, 100, 360)));
      send(make_word(CMD_ADD, 85, span(1000, 3000, 300, 500, -200, 200)));
      send(make_word(CMD_EVAL, 86, span(1000, 1500, 400, 400, 0, 0)));
      run_random(PHASE_ITEMS);

      pause_until_drained();
      set_request(4, 200, -360, 200, 0);
      run_random(PHASE_ITEMS);
      pause_until_drained();
      set_request(4000, 800, 360, 800, 360);
      run_random(PHASE_ITEMS);
      pause_until_drained();
      set_request(2000, 800, -360, 200, 360);
      run_random(PHASE_ITEMS);
      pause_until_drained();
      set_request(1600, 200, 360, 800, 0);
      run_random(PHASE_ITEMS);
      for (int p = 0; p < 6; p++) begin
         pause_until_drained();
         random_request();
         run_random(PHASE_ITEMS);
      end

      pause_until_drained();
      repeat (10) @(posedge clock);
      if (tracker.faults == 0 && tracker.awaited_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
